// ===== sv/tgq_pkg.sv =====
// ----------------------------------------------------------------------------
// tgq_pkg
// Shared types, codes and helpers of the team grouped queue.
// ----------------------------------------------------------------------------
package tgq_pkg;

  // Default sizes
  localparam int ELEMENT_IDS_DEF = 1024;
  localparam int TEAMS_DEF       = 16;
  localparam int TEAM_DEPTH_DEF  = 64;

  // Fixed field widths of the transfer payloads
  localparam int ELEM_W    = 10;
  localparam int TEAM_IN_W = 4;

  // Remainder steps cover the widest input field
  localparam int MOD_STEPS = ELEM_W;

  typedef enum logic [1:0] {
    ACT_ASSIGN  = 2'd0,
    ACT_ENQUEUE = 2'd1,
    ACT_DEQUEUE = 2'd2,
    ACT_CLEAR   = 2'd3
  } tgq_action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } tgq_status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_SWEEP,
    S_IDLE,
    S_MAP,
    S_PTR,
    S_DATA,
    S_OUT
  } tgq_state_t;

  typedef struct packed {
    logic [1:0]           action;
    logic [ELEM_W-1:0]    element;
    logic [TEAM_IN_W-1:0] team;
  } tgq_in_t;

  typedef struct packed {
    logic [ELEM_W-1:0] out_element;
    logic              out_valid;
    logic [1:0]        status;
  } tgq_out_t;

  // Remainder of a narrow value by a constant, by shifted compare and subtract
  function automatic logic [31:0] reduce_mod(input logic [31:0] v, input int unsigned n);
    logic [31:0] r;
    logic [31:0] d;
    r = v;
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      d = 32'(n) << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/tgq_ptr_table.sv =====
// ----------------------------------------------------------------------------
// tgq_ptr_table
// Per-team head, tail and count table: synchronous memory with one read and
// one write port, plus a valid bit per team so that a clear needs no sweep of the memory.
// ----------------------------------------------------------------------------
module tgq_ptr_table #(
  parameter int TEAMS = tgq_pkg::TEAMS_DEF,
  parameter int WIDTH = 2 * $clog2(tgq_pkg::TEAM_DEPTH_DEF)
                        + $clog2(tgq_pkg::TEAM_DEPTH_DEF + 1)
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    clear,
  input  logic [((TEAMS > 1) ? $clog2(TEAMS) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data,
  input  logic                                    wr_en,
  input  logic [((TEAMS > 1) ? $clog2(TEAMS) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data
);

  logic [WIDTH-1:0] mem [TEAMS];
  logic [TEAMS-1:0] valid;
  logic [WIDTH-1:0] rd_raw;
  logic             rd_hit;

  // Write and registered read of the pointer words
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_raw <= mem[rd_addr];
  end

  // Track which teams have been written since the last clear
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_hit <= valid[rd_addr];
    end
  end

  // An unwritten team reads as empty
  assign rd_data = rd_hit ? rd_raw : '0;

endmodule

// ===== sv/team_grouped_queue_unit.sv =====
// Assign and dequeue-on-empty finish in the idle state; enqueue goes through the
// team map read and the pointer read, dequeue through the order read, the pointer
// read and the element memory read. One item in flight at a time.
// Clear: a sweep zeroes the team map, one entry a cycle.
// Reset runs the same sweep with item_stall held high.
// ----------------------------------------------------------------------------
// team_grouped_queue_unit
// Team queue: per-team circular FIFOs in one element memory, a team-order
// FIFO of non-empty teams, and a team map from element to team.
// ----------------------------------------------------------------------------
module team_grouped_queue_unit #(
  parameter int ELEMENT_IDS = tgq_pkg::ELEMENT_IDS_DEF,
  parameter int TEAMS       = tgq_pkg::TEAMS_DEF,
  parameter int TEAM_DEPTH  = tgq_pkg::TEAM_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  tgq_pkg::tgq_in_t  item,
  output logic              result_valid,
  input  logic              result_stall,
  output tgq_pkg::tgq_out_t result
);

  import tgq_pkg::*;

  localparam int EID_W  = (ELEMENT_IDS > 1) ? $clog2(ELEMENT_IDS) : 1;
  localparam int TEAM_W = (TEAMS > 1) ? $clog2(TEAMS) : 1;
  localparam int SLOT_W = (TEAM_DEPTH > 1) ? $clog2(TEAM_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TEAM_DEPTH + 1);
  localparam int OCNT_W = $clog2(TEAMS + 1);
  localparam int PTR_W  = 2 * SLOT_W + CNT_W;
  localparam int SA_W   = TEAM_W + SLOT_W;
  localparam int SLOTS  = 1 << SA_W;

  tgq_state_t        state, state_next;
  logic [EID_W-1:0]  sweep;
  tgq_action_t       act_q;
  logic [ELEM_W-1:0] elem_q;
  logic [TEAM_W-1:0] team_q;
  tgq_out_t          res;

  logic [TEAM_W-1:0] order_head, order_head_next;
  logic [TEAM_W-1:0] order_tail, order_tail_next;
  logic [OCNT_W-1:0] order_count, order_count_next;

  // Team map memory
  logic [TEAM_W-1:0] member_mem [ELEMENT_IDS];
  logic [TEAM_W-1:0] member_rd;
  logic              map_we;
  logic [EID_W-1:0]  map_wa;
  logic [EID_W-1:0]  map_ra;
  logic [TEAM_W-1:0] map_wd;

  // Element memory holding every team FIFO
  logic [ELEM_W-1:0] slot_mem [SLOTS];
  logic [ELEM_W-1:0] slot_rd;
  logic              slot_we;
  logic [SA_W-1:0]   slot_wa;
  logic [SA_W-1:0]   slot_ra;

  // Team-order FIFO memory
  logic [TEAM_W-1:0] order_mem [TEAMS];
  logic [TEAM_W-1:0] order_rd;
  logic              order_we;

  // Pointer table
  logic [TEAM_W-1:0] ptr_ra;
  logic [PTR_W-1:0]  ptr_rd;
  logic              ptr_we;
  logic [PTR_W-1:0]  ptr_wd;
  logic              ptr_clear;
  logic [SLOT_W-1:0] p_head, p_tail, head_inc, tail_inc;
  logic [CNT_W-1:0]  p_count;

  logic              accept;
  logic              out_free;
  logic              fin;
  tgq_out_t          fin_res;
  logic [ELEM_W-1:0] in_elem;
  logic [TEAM_W-1:0] in_team;

  assign accept   = item_valid && !item_stall;
  assign item_stall = (state != S_IDLE);
  assign out_free = !result_valid || !result_stall;

  // Reduce identifiers into range
  assign in_elem = ELEM_W'(reduce_mod(32'(item.element), ELEMENT_IDS));
  assign in_team = TEAM_W'(reduce_mod(32'(item.team), TEAMS));
  assign map_ra  = EID_W'(in_elem);

  // Unpack the pointer word and step the ring indices
  assign p_head   = ptr_rd[PTR_W-1 -: SLOT_W];
  assign p_tail   = ptr_rd[CNT_W+SLOT_W-1 -: SLOT_W];
  assign p_count  = ptr_rd[CNT_W-1:0];
  assign head_inc = (p_head == SLOT_W'(TEAM_DEPTH - 1)) ? '0 : p_head + SLOT_W'(1);
  assign tail_inc = (p_tail == SLOT_W'(TEAM_DEPTH - 1)) ? '0 : p_tail + SLOT_W'(1);

  tgq_ptr_table #(
    .TEAMS (TEAMS),
    .WIDTH (PTR_W)
  ) u_ptr (
    .clk     (clk),
    .rst     (rst),
    .clear   (ptr_clear),
    .rd_addr (ptr_ra),
    .rd_data (ptr_rd),
    .wr_en   (ptr_we),
    .wr_addr (team_q),
    .wr_data (ptr_wd)
  );

  // Next state, memory controls and result
  always_comb begin
    state_next       = state;
    map_we           = 1'b0;
    map_wa           = map_ra;
    map_wd           = in_team;
    slot_we          = 1'b0;
    slot_wa          = {team_q, p_tail};
    slot_ra          = {team_q, p_head};
    order_we         = 1'b0;
    ptr_ra           = team_q;
    ptr_we           = 1'b0;
    ptr_wd           = ptr_rd;
    ptr_clear        = 1'b0;
    order_head_next  = order_head;
    order_tail_next  = order_tail;
    order_count_next = order_count;
    fin              = 1'b0;
    fin_res          = '0;
    case (state)
      S_INIT, S_SWEEP: begin
        map_we = 1'b1;
        map_wa = sweep;
        map_wd = '0;
        if (sweep == EID_W'(ELEMENT_IDS - 1)) begin
          if (state == S_SWEEP) begin
            fin = 1'b1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (item.action)
            ACT_ASSIGN: begin
              map_we = 1'b1;
              fin    = 1'b1;
            end
            ACT_ENQUEUE: begin
              state_next = S_MAP;
            end
            ACT_DEQUEUE: begin
              if (order_count == '0) begin
                fin            = 1'b1;
                fin_res.status = ST_EMPTY;
              end else begin
                state_next = S_MAP;
              end
            end
            default: begin
              ptr_clear        = 1'b1;
              order_head_next  = '0;
              order_tail_next  = '0;
              order_count_next = '0;
              state_next       = S_SWEEP;
            end
          endcase
        end
      end
      S_MAP: begin
        ptr_ra     = (act_q == ACT_ENQUEUE) ? member_rd : order_rd;
        state_next = S_PTR;
      end
      S_PTR: begin
        if (act_q == ACT_ENQUEUE) begin
          fin = 1'b1;
          if (p_count == CNT_W'(TEAM_DEPTH)) begin
            fin_res.status = ST_FULL;
          end else begin
            slot_we = 1'b1;
            ptr_we  = 1'b1;
            ptr_wd  = {p_head, tail_inc, p_count + CNT_W'(1)};
            // A team that was empty joins the order FIFO
            if (p_count == '0 && order_count != OCNT_W'(TEAMS)) begin
              order_we         = 1'b1;
              order_tail_next  = (order_tail == TEAM_W'(TEAMS - 1)) ? '0
                                 : order_tail + TEAM_W'(1);
              order_count_next = order_count + OCNT_W'(1);
            end
          end
        end else begin
          if (p_count != '0) begin
            ptr_we     = 1'b1;
            ptr_wd     = {head_inc, p_tail, p_count - CNT_W'(1)};
            state_next = S_DATA;
          end else begin
            fin               = 1'b1;
            fin_res.out_valid = 1'b1;
          end
          // Drop the team from the order FIFO once it runs empty
          if (p_count <= CNT_W'(1)) begin
            order_head_next  = (order_head == TEAM_W'(TEAMS - 1)) ? '0
                               : order_head + TEAM_W'(1);
            order_count_next = order_count - OCNT_W'(1);
          end
        end
      end
      S_DATA: begin
        fin                 = 1'b1;
        fin_res.out_valid   = 1'b1;
        fin_res.out_element = slot_rd;
      end
      S_OUT: begin
        fin     = 1'b1;
        fin_res = res;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
    // Finish: hand over now if the output is free, else hold
    if (fin) begin
      state_next = out_free ? S_IDLE : S_OUT;
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      sweep       <= '0;
      order_head  <= '0;
      order_tail  <= '0;
      order_count <= '0;
    end else begin
      state       <= state_next;
      order_head  <= order_head_next;
      order_tail  <= order_tail_next;
      order_count <= order_count_next;
      if (state == S_INIT || state == S_SWEEP) begin
        sweep <= sweep + EID_W'(1);
      end else begin
        sweep <= '0;
      end
    end
  end

  // Item and result holding registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_q  <= tgq_action_t'(item.action);
      elem_q <= in_elem;
    end
    if (state == S_MAP) begin
      team_q <= ptr_ra;
    end
    if (fin && !out_free) begin
      res <= fin_res;
    end
  end

  // Output register: load on finish, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fin && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin && out_free) begin
      result <= fin_res;
    end
  end

  // Team map memory
  always_ff @(posedge clk) begin
    if (map_we) begin
      member_mem[map_wa] <= map_wd;
    end
    member_rd <= member_mem[map_ra];
  end

  // Element memory
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= elem_q;
    end
    slot_rd <= slot_mem[slot_ra];
  end

  // Team-order memory
  always_ff @(posedge clk) begin
    if (order_we) begin
      order_mem[order_tail] <= team_q;
    end
    order_rd <= order_mem[order_head];
  end

endmodule

// ===== tb/team_grouped_queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// team_grouped_queue_checker
// Watches both channels of the team queue, keeps its own copy of the team
// map, the per-team FIFOs and the team-order FIFO, and compares each result
// transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module team_grouped_queue_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  tgq_pkg::tgq_in_t  item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  tgq_pkg::tgq_out_t result,
  output int                fails,
  output int                outstanding
);
  import tgq_pkg::*;

  // Shadow state of the queue
  logic [3:0] team_of [1024];
  logic [9:0] slot_mem [16][64];
  logic [5:0] slot_rd [16];
  logic [5:0] slot_wr [16];
  logic [6:0] slot_fill [16];
  logic [3:0] team_order [16];
  logic [3:0] order_rd;
  logic [3:0] order_wr;
  logic [4:0] order_fill;

  tgq_out_t predicted_results[$];

  initial begin
    fails       = 0;
    outstanding = 0;
  end

  // Return every piece of shadow state to its cleared value
  function automatic void clear_team_queue();
    for (int i = 0; i < 1024; i++) begin
      team_of[i] = '0;
    end
    for (int t = 0; t < 16; t++) begin
      for (int s = 0; s < 64; s++) begin
        slot_mem[t][s] = '0;
      end
      slot_rd[t]    = '0;
      slot_wr[t]    = '0;
      slot_fill[t]  = '0;
      team_order[t] = '0;
    end
    order_rd   = '0;
    order_wr   = '0;
    order_fill = '0;
  endfunction

  // Apply one operation to the shadow state and return its result
  function automatic tgq_out_t apply_team_op(input tgq_in_t op);
    tgq_out_t   r;
    logic [3:0] t;
    r = '0;
    r.status = ST_OK;
    case (tgq_action_t'(op.action))
      ACT_ASSIGN: begin
        team_of[op.element] = op.team;
      end
      ACT_ENQUEUE: begin
        t = team_of[op.element];
        if (slot_fill[t] >= 7'd64) begin
          r.status = ST_FULL;
        end else begin
          slot_mem[t][slot_wr[t]] = op.element;
          slot_wr[t]   = slot_wr[t] + 6'd1;
          slot_fill[t] = slot_fill[t] + 7'd1;
          // a team that has just become non-empty joins the order FIFO
          if (slot_fill[t] == 7'd1 && order_fill < 5'd16) begin
            team_order[order_wr] = t;
            order_wr   = order_wr + 4'd1;
            order_fill = order_fill + 5'd1;
          end
        end
      end
      ACT_DEQUEUE: begin
        if (order_fill == 5'd0) begin
          r.status = ST_EMPTY;
        end else begin
          t = team_order[order_rd];
          if (slot_fill[t] != 7'd0) begin
            r.out_element = slot_mem[t][slot_rd[t]];
            slot_rd[t]    = slot_rd[t] + 6'd1;
            slot_fill[t]  = slot_fill[t] - 7'd1;
          end
          // drop the front team once it has run dry
          if (slot_fill[t] == 7'd0) begin
            order_rd   = order_rd + 4'd1;
            order_fill = order_fill - 5'd1;
          end
          r.out_valid = 1'b1;
        end
      end
      default: begin
        clear_team_queue();
      end
    endcase
    return r;
  endfunction

  // Predict on each item transfer, compare on each result transfer
  always @(posedge clk) begin
    tgq_out_t want;
    if (rst) begin
      clear_team_queue();
      predicted_results.delete();
      outstanding <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (predicted_results.size() == 0) begin
          if (fails < 10) begin
            $display("%0t: unexpected result: element %0d valid %0d status %0d",
                     $realtime, result.out_element, result.out_valid, result.status);
          end
          fails++;
        end else begin
          want = predicted_results.pop_front();
          if (result.out_element !== want.out_element ||
              result.out_valid !== want.out_valid ||
              result.status !== want.status) begin
            if (fails < 10) begin
              $display("%0t: result mismatch: element %0d/%0d valid %0d/%0d status %0d/%0d",
                       $realtime, want.out_element, result.out_element,
                       want.out_valid, result.out_valid, want.status, result.status);
            end
            fails++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        predicted_results.push_back(apply_team_op(item));
      end
      outstanding <= predicted_results.size();
    end
  end

endmodule

// ===== tb/team_grouped_queue_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// team_grouped_queue_unit_tb
// Drives the team queue with a directed opening and then random traffic:
// mixed assign/enqueue/dequeue on a small element pool, team fills past
// full, drains past empty, clears and raw noise. Bursty sender, patterned
// receiver stalls; the checker beside the block scores every result.
// ----------------------------------------------------------------------------
module team_grouped_queue_unit_tb;
  import tgq_pkg::*;

  typedef enum int {RX_FREE, RX_RANDOM, RX_TOGGLE, RX_HOLD} rx_mode_t;

  logic      clk          = 1'b0;
  logic      rst          = 1'b1;
  logic      item_valid   = 1'b0;
  logic      item_stall;
  tgq_in_t   item         = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  tgq_out_t  result;

  int        fails;
  int        outstanding;
  int        ops_sent     = 0;
  int        burst_left   = 0;
  rx_mode_t  rx_mode      = RX_FREE;
  int        rx_left      = 0;
  logic [9:0] elem_pool [32];

  always #1 clk = ~clk;

  team_grouped_queue_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  team_grouped_queue_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fails        (fails),
    .outstanding  (outstanding)
  );

  // Receiver stalls in stretches of one pattern each
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(5, 60);
    end
    rx_left--;
    case (rx_mode)
      RX_FREE:   result_stall <= 1'b0;
      RX_RANDOM: result_stall <= ($urandom_range(0, 99) < 35);
      RX_TOGGLE: result_stall <= ~result_stall;
      default:   result_stall <= (rx_left >= 3);
    endcase
  end

  // Send one operation, opening a new burst after a random gap when due
  task automatic send_op(input tgq_action_t act, input logic [9:0] elem,
                         input logic [3:0] tm);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    item_valid <= 1'b1;
    item       <= {act, elem, tm};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    burst_left--;
    ops_sent++;
  endtask

  // Hold the sender until every predicted result has come back
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // Mostly ids from the pool so that teams fill up; now and then any id
  function automatic logic [9:0] pick_elem();
    if ($urandom_range(0, 99) < 85) begin
      return elem_pool[$urandom_range(0, 31)];
    end
    return 10'($urandom_range(0, 1023));
  endfunction

  initial begin
    int pick;
    int n;
    int a;
    logic [3:0] t;
    logic [9:0] fill_ids [3];

    elem_pool[0] = 10'd0;
    elem_pool[1] = 10'd1023;
    for (int i = 2; i < 32; i++) begin
      elem_pool[i] = 10'($urandom_range(0, 1023));
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: empty dequeue, extreme ids and teams, default team,
    // reassignment of a queued element, clear with work pending
    send_op(ACT_DEQUEUE, 10'd1023, 4'd15);
    send_op(ACT_ASSIGN,  10'd1023, 4'd15);
    send_op(ACT_ASSIGN,  10'd0,    4'd0);
    send_op(ACT_ASSIGN,  10'd682,  4'd10);
    send_op(ACT_ASSIGN,  10'd341,  4'd5);
    send_op(ACT_ENQUEUE, 10'd1023, 4'd0);
    send_op(ACT_ENQUEUE, 10'd5,    4'd0);
    send_op(ACT_ENQUEUE, 10'd682,  4'd0);
    send_op(ACT_ENQUEUE, 10'd0,    4'd15);
    send_op(ACT_ASSIGN,  10'd1023, 4'd3);
    send_op(ACT_ENQUEUE, 10'd1023, 4'd0);
    repeat (6) send_op(ACT_DEQUEUE, 10'd0, 4'd0);
    send_op(ACT_ENQUEUE, 10'd341,  4'd0);
    send_op(ACT_CLEAR,   10'd0,    4'd0);
    send_op(ACT_DEQUEUE, 10'd0,    4'd0);
    send_op(ACT_ENQUEUE, 10'd1023, 4'd0);
    send_op(ACT_DEQUEUE, 10'd0,    4'd0);
    wait_drained();

    // Random traffic
    while (ops_sent < 600) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // mixed traffic on the pool
        n = $urandom_range(8, 30);
        repeat (n) begin
          a = $urandom_range(0, 99);
          if (a < 20) begin
            send_op(ACT_ASSIGN, pick_elem(), 4'($urandom_range(0, 15)));
          end else if (a < 65) begin
            send_op(ACT_ENQUEUE, pick_elem(), 4'($urandom_range(0, 15)));
          end else begin
            send_op(ACT_DEQUEUE, 10'($urandom_range(0, 1023)),
                    4'($urandom_range(0, 15)));
          end
        end
      end else if (pick < 58) begin
        // push one team past full, then take some back
        t = 4'($urandom_range(0, 15));
        for (int i = 0; i < 3; i++) begin
          fill_ids[i] = pick_elem();
          send_op(ACT_ASSIGN, fill_ids[i], t);
        end
        n = $urandom_range(65, 68);
        repeat (n) send_op(ACT_ENQUEUE, fill_ids[$urandom_range(0, 2)],
                           4'($urandom_range(0, 15)));
        n = $urandom_range(10, 40);
        repeat (n) send_op(ACT_DEQUEUE, pick_elem(), 4'($urandom_range(0, 15)));
      end else if (pick < 70) begin
        // drain, usually past empty
        n = $urandom_range(10, 70);
        repeat (n) send_op(ACT_DEQUEUE, pick_elem(), 4'($urandom_range(0, 15)));
      end else if (pick < 74) begin
        send_op(ACT_CLEAR, 10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)));
      end else if (pick < 80) begin
        wait_drained();
      end else begin
        // raw noise over the full element and team ranges
        n = $urandom_range(3, 12);
        repeat (n) send_op(tgq_action_t'($urandom_range(0, 2)),
                           10'($urandom_range(0, 1023)),
                           4'($urandom_range(0, 15)));
      end
    end

    // Drain, then give any stray result time to show up
    wait_drained();
    repeat (20) @(posedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
